>>> rtl/mrsp_pkg.sv
// Shared constants and types for the sparse-prime Montgomery reduction block.
// Used by the sequencer top level and the shared multiply-accumulate unit.
// No dependencies.
package mrsp_pkg;

    localparam int FIELD_WORDS = 8;
    localparam int ZERO_WORDS  = 3;
    localparam int CFG_COUNT   = 5;

    localparam int WORD_W = 64;
    localparam int HALF_W = WORD_W / 2;
    localparam int ACC_W  = 2 * WORD_W + 8;

    // load count, quotient index, register index widths
    localparam int KW  = $clog2(2 * FIELD_WORDS);
    localparam int JW  = $clog2(FIELD_WORDS);
    localparam int CIW = $clog2(CFG_COUNT);
    localparam int SW  = KW + 2;
    localparam int MW  = KW + CIW;

    // highest word of p+1 that ever meets a quotient word
    localparam int MIDX_HI = (ZERO_WORDS + CFG_COUNT - 1 < FIELD_WORDS - 1) ?
                             (ZERO_WORDS + CFG_COUNT - 1) : (FIELD_WORDS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_WRITE,
        ST_OUT
    } seq_state_t;

    typedef struct packed {
        logic       issue;     // start a 32x32 partial product
        logic [1:0] shift;     // partial product weight in half words
        logic       add_word;  // add product word, store column, shift down
        logic       clear;     // final column: zero the accumulator
    } acc_ctrl_t;

endpackage

>>> rtl/montgomery_reduction_sparse_prime.sv
// Montgomery reduction against a sparse prime (p+1 with zero low words).
// Column sequencer, quotient store and p+1 registers; uses mrsp_mul_acc.
// Depends on mrsp_pkg.
// Flow: a product word whose column needs n products (n <= 5) is taken
// and stalls further input until written; each 64x64 product is four 32x32
// passes through the single shared multiplier. After the last word is
// written, 8 result words follow at one per cycle when not stalled.
// Reset (async, rst_n low) clears the sequencer, accumulator and p+1 registers.
module montgomery_reduction_sparse_prime (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         product_valid,
    output logic                         product_stall,
    input  logic [mrsp_pkg::WORD_W-1:0]  product_word,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [mrsp_pkg::WORD_W-1:0]  result_word,
    output logic                         result_last,
    input  logic                         cfg_write,
    input  logic [mrsp_pkg::CIW-1:0]     cfg_index,
    input  logic [mrsp_pkg::WORD_W-1:0]  cfg_data
);
    import mrsp_pkg::*;

    localparam logic signed [SW-1:0] FW_S = SW'(FIELD_WORDS);
    localparam logic signed [SW-1:0] ZW_S = SW'(ZERO_WORDS);
    localparam logic signed [SW-1:0] MH_S = SW'(MIDX_HI);

    seq_state_t state_reg, state_next;

    logic [KW-1:0]     load_count_reg;
    logic [JW-1:0]     j_reg;
    logic [JW-1:0]     j_end_reg;
    logic [1:0]        part_reg;
    logic [JW-1:0]     out_idx_reg;
    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] modp1_reg [CFG_COUNT];
    logic [WORD_W-1:0] q_mem [FIELD_WORDS];

    logic signed [SW-1:0] k_s, lo1, lo2, hi1, hi2, j_lo, j_hi;
    logic              low_half;
    logic              final_col;
    logic              col_any;
    logic [KW-1:0]     col_k;
    logic [JW-1:0]     col_idx;
    logic [MW-1:0]     midx;
    logic [MW-1:0]     cidx_full;
    logic [WORD_W-1:0] m_word;
    logic [JW-1:0]     rd_idx;
    logic [WORD_W-1:0] q_word;
    logic [HALF_W-1:0] op_a, op_b;
    logic [WORD_W-1:0] sum_low;
    logic              mac_done;
    logic              out_done;
    acc_ctrl_t         ctrl;

    // Column bounds: only quotient words that meet a programmed word of p+1.
    always_comb
    begin
        k_s       = $signed({2'b00, load_count_reg});
        low_half  = load_count_reg < KW'(FIELD_WORDS);
        final_col = load_count_reg == KW'(2 * FIELD_WORDS - 1);
        lo1       = low_half ? '0 : (k_s - FW_S + SW'(1));
        lo2       = k_s - MH_S;
        hi1       = low_half ? (k_s - SW'(1)) : (FW_S - SW'(1));
        hi2       = k_s - ZW_S;
        j_lo      = (lo1 > lo2) ? lo1 : lo2;
        j_hi      = (hi1 < hi2) ? hi1 : hi2;
        col_any   = (j_lo <= j_hi) && !final_col;
        col_k     = low_half ? load_count_reg : (load_count_reg - KW'(FIELD_WORDS));
        col_idx   = col_k[JW-1:0];
    end

    always_comb
    begin
        midx      = MW'(load_count_reg) - MW'(j_reg);
        cidx_full = midx - MW'(ZERO_WORDS);
        if (cidx_full < MW'(CFG_COUNT))
        begin
            m_word = modp1_reg[cidx_full[CIW-1:0]];
        end
        else
        begin
            m_word = '0;
        end
    end

    assign rd_idx   = (state_reg == ST_OUT) ? out_idx_reg : j_reg;
    assign q_word   = q_mem[rd_idx];
    assign op_a     = part_reg[0] ? q_word[WORD_W-1:HALF_W] : q_word[HALF_W-1:0];
    assign op_b     = part_reg[1] ? m_word[WORD_W-1:HALF_W] : m_word[HALF_W-1:0];
    assign mac_done = (part_reg == 2'd3) && (j_reg == j_end_reg);
    assign out_done = !result_stall && (out_idx_reg == JW'(FIELD_WORDS - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (product_valid)
                begin
                    state_next = col_any ? ST_MAC : ST_WRITE;
                end
            end
            ST_MAC:
            begin
                if (mac_done)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_WRITE;
            ST_WRITE: state_next = final_col ? ST_OUT : ST_IDLE;
            ST_OUT:
            begin
                if (out_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs and unit control
    always_comb
    begin
        product_stall = state_reg != ST_IDLE;
        result_valid  = state_reg == ST_OUT;
        result_word   = q_word;
        result_last   = (state_reg == ST_OUT) && (out_idx_reg == JW'(FIELD_WORDS - 1));
        ctrl.issue    = state_reg == ST_MAC;
        ctrl.shift    = {1'b0, part_reg[0]} + {1'b0, part_reg[1]};
        ctrl.add_word = state_reg == ST_WRITE;
        ctrl.clear    = final_col;
    end

    mrsp_mul_acc u_mul_acc (
        .clk     (clk),
        .rst_n   (rst_n),
        .op_a    (op_a),
        .op_b    (op_b),
        .ctrl    (ctrl),
        .word    (word_reg),
        .sum_low (sum_low)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && product_valid)
        begin
            word_reg <= product_word;
        end
        if (state_reg == ST_WRITE)
        begin
            q_mem[col_idx] <= sum_low;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            load_count_reg <= '0;
            j_reg          <= '0;
            j_end_reg      <= '0;
            part_reg       <= '0;
            out_idx_reg    <= '0;
            for (int i = 0; i < CFG_COUNT; i++)
            begin
                modp1_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write && (cfg_index < CIW'(CFG_COUNT)))
            begin
                modp1_reg[cfg_index] <= cfg_data;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    j_reg     <= j_lo[JW-1:0];
                    j_end_reg <= j_hi[JW-1:0];
                    part_reg  <= '0;
                end
                ST_MAC:
                begin
                    part_reg <= part_reg + 2'd1;
                    if (part_reg == 2'd3 && !mac_done)
                    begin
                        j_reg <= j_reg + JW'(1);
                    end
                end
                ST_WRITE:
                begin
                    load_count_reg <= final_col ? '0 : (load_count_reg + KW'(1));
                    out_idx_reg    <= '0;
                end
                ST_OUT:
                begin
                    if (!result_stall && !out_done)
                    begin
                        out_idx_reg <= out_idx_reg + JW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

>>> rtl/mrsp_mul_acc.sv
// Shared 32x32 multiplier with a registered partial product and the
// 136-bit column accumulator. Depends on mrsp_pkg.
module mrsp_mul_acc (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [mrsp_pkg::HALF_W-1:0] op_a,
    input  logic [mrsp_pkg::HALF_W-1:0] op_b,
    input  mrsp_pkg::acc_ctrl_t         ctrl,
    input  logic [mrsp_pkg::WORD_W-1:0] word,
    output logic [mrsp_pkg::WORD_W-1:0] sum_low
);
    import mrsp_pkg::*;

    logic [WORD_W-1:0] pp_reg;
    logic [1:0]        pp_shift_reg;
    logic              pp_valid_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;
    logic [ACC_W-1:0]  pp_ext;
    logic [ACC_W-1:0]  pp_placed;
    logic [ACC_W-1:0]  word_sum;

    assign pp_ext   = {{(ACC_W - WORD_W){1'b0}}, pp_reg};
    assign word_sum = acc_reg + {{(ACC_W - WORD_W){1'b0}}, word};
    assign sum_low  = word_sum[WORD_W-1:0];

    always_comb
    begin
        case (pp_shift_reg)
            2'd0:    pp_placed = pp_ext;
            2'd1:    pp_placed = pp_ext << HALF_W;
            2'd2:    pp_placed = pp_ext << (2 * HALF_W);
            default: pp_placed = pp_ext << (3 * HALF_W);
        endcase
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (pp_valid_reg)
        begin
            acc_next = acc_reg + pp_placed;
        end
        else if (ctrl.add_word)
        begin
            if (ctrl.clear)
            begin
                acc_next = '0;
            end
            else
            begin
                acc_next = {{WORD_W{1'b0}}, word_sum[ACC_W-1:WORD_W]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.issue)
        begin
            pp_reg <= WORD_W'(op_a) * WORD_W'(op_b);
        end
        pp_shift_reg <= ctrl.shift;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pp_valid_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            pp_valid_reg <= ctrl.issue;
            acc_reg      <= acc_next;
        end
    end

endmodule

>>> rtl/mrsp_checker.sv
// Port-level checks for montgomery_reduction_sparse_prime, bound to the top.
// Depends only on the top level's ports.
module mrsp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        product_valid,
    input logic        product_stall,
    input logic        result_valid,
    input logic        result_stall,
    input logic [63:0] result_word,
    input logic        result_last
);

    // no product transaction while results are being delivered
    a_no_input_during_output: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> product_stall)
        else $error("product accepted while results pending");

    // each accepted product word is followed by a stall: the block goes busy
    a_busy_after_input: assert property (@(posedge clk) disable iff (!rst_n)
        (product_valid && !product_stall) |=> product_stall)
        else $error("input ready right after a transaction");

    // the last result transaction ends the burst
    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && result_last) |=> !result_valid)
        else $error("result valid after last word");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=>
            (result_valid && $stable(result_word) && $stable(result_last)))
        else $error("stalled result changed");

endmodule

bind montgomery_reduction_sparse_prime mrsp_checker u_mrsp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .product_valid (product_valid),
    .product_stall (product_stall),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result_word   (result_word),
    .result_last   (result_last)
);

>>> test/montgomery_reduction_sparse_prime_tb.sv
// Self-checking testbench for montgomery_reduction_sparse_prime: streams products, programs
// the p+1 words between phases and checks every result word against a column-scan predictor.
// Depends on mrsp_pkg and the RTL top level only.
`timescale 1ns / 100ps

module montgomery_reduction_sparse_prime_tb;
    import mrsp_pkg::*;

    localparam int          PRODUCT_WORDS = 2 * FIELD_WORDS;
    localparam int          REG_SLOTS     = 1 << CIW;
    localparam int          WORD_TARGET   = 380;
    localparam int          DRAIN_CYCLES  = 30;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          GAP_PERCENT   = 34;
    localparam int          PRINT_CAP     = 40;
    localparam logic [63:0] ALL_ONES      = {WORD_W{1'b1}};

    typedef enum int {
        FILL_ZERO,
        FILL_ONES,
        FILL_RANDOM
    } modp1_fill_t;

    typedef struct packed {
        logic        word_last;
        logic [63:0] word;
    } reduced_word_t;

    // directed product: low and high halves filled with one value each
    typedef struct packed {
        logic        load_ones;
        logic [63:0] low_fill;
        logic [63:0] high_fill;
        logic        typed;
        logic [63:0] typed_word;
    } dir_row_t;

    logic              clk;
    logic              rst_n;
    logic              product_valid;
    logic              product_stall;
    logic [WORD_W-1:0] product_word;
    logic              result_valid;
    logic              result_stall;
    logic [WORD_W-1:0] result_word;
    logic              result_last;
    logic              cfg_write;
    logic [CIW-1:0]    cfg_index;
    logic [WORD_W-1:0] cfg_data;

    // predictor state
    logic [63:0]       modp1_words [CFG_COUNT];
    logic [63:0]       quot_words [FIELD_WORDS];
    logic [ACC_W-1:0]  mont_acc;
    int                column;
    reduced_word_t     reduced_q [$];

    bit                gaps_on;
    bit                hold_req;
    int                error_count;
    int                words_in;
    int                products_done;
    int                results_checked;
    int                settings_used;

    montgomery_reduction_sparse_prime u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .product_valid (product_valid),
        .product_stall (product_stall),
        .product_word  (product_word),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result_word   (result_word),
        .result_last   (result_last),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    // One column of product-scanning reduction per accepted word; the last word
    // closes the product and queues the eight reduced words.
    task automatic reduce_column(input logic [63:0] w, input logic typed,
                                 input logic [63:0] typed_word);
        int            k;
        int            j;
        logic [63:0]   m;
        logic [127:0]  prod;
        reduced_word_t r;
        k = column;
        if (k < PRODUCT_WORDS - 1)
        begin
            for (j = (k < FIELD_WORDS) ? 0 : k - FIELD_WORDS + 1;
                 j < FIELD_WORDS && j < k; j++)
            begin
                // words of p+1 below ZERO_WORDS are zero, none above the registers
                m = '0;
                if (k - j >= ZERO_WORDS && k - j < ZERO_WORDS + CFG_COUNT)
                    m = modp1_words[k - j - ZERO_WORDS];
                prod = 128'(quot_words[j]) * 128'(m);
                mont_acc = mont_acc + prod;
            end
            mont_acc = mont_acc + w;
            quot_words[(k < FIELD_WORDS) ? k : k - FIELD_WORDS] = mont_acc[63:0];
            mont_acc = mont_acc >> WORD_W;
            column = k + 1;
        end
        else
        begin
            // carry out of the final column is dropped
            quot_words[FIELD_WORDS - 1] = mont_acc[63:0] + w;
            for (j = 0; j < FIELD_WORDS; j++)
            begin
                r.word      = typed ? typed_word : quot_words[j];
                r.word_last = (j == FIELD_WORDS - 1);
                reduced_q.push_back(r);
            end
            mont_acc = '0;
            column   = 0;
            products_done++;
        end
    endtask

    task automatic send_word(input logic [63:0] w, input logic typed,
                             input logic [63:0] typed_word);
        bit taken;
        while (gaps_on && $urandom_range(0, 99) < GAP_PERCENT)
        begin
            product_valid <= 1'b0;
            @(posedge clk);
        end
        product_valid <= 1'b1;
        product_word  <= w;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !product_stall;
            @(posedge clk);
        end
        words_in++;
        reduce_column(w, typed, typed_word);
    endtask

    // drop valid, wait for every outstanding result, then let the block go quiet
    task automatic settle();
        product_valid <= 1'b0;
        while (reduced_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_modulus(input modp1_fill_t fill);
        int          i;
        int          pick;
        logic [63:0] v;
        for (i = 0; i < REG_SLOTS; i++)
        begin
            case (fill)
                FILL_ZERO: v = '0;
                FILL_ONES: v = ALL_ONES;
                default:
                begin
                    pick = $urandom_range(0, 9);
                    v = (pick == 0) ? '0 : (pick == 1) ? ALL_ONES : {$urandom, $urandom};
                end
            endcase
            // indexes past the register list must be ignored by the block
            if (i >= CFG_COUNT)
                v = {$urandom, $urandom};
            cfg_write <= 1'b1;
            cfg_index <= i[CIW-1:0];
            cfg_data  <= v;
            @(posedge clk);
            if (i < CFG_COUNT)
                modp1_words[i] = v;
        end
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // receiver: random stalls, or a long hold when asked
    initial
    begin
        int hold_left;
        hold_left = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= gaps_on && ($urandom_range(0, 99) < GAP_PERCENT);
        end
    end

    // result checker: a transaction completes at the next rising edge
    initial
    begin
        reduced_word_t want;
        int            pos;
        forever
        begin
            @(negedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                pos = results_checked % FIELD_WORDS;
                if (reduced_q.size() == 0)
                    flag_mismatch($sformatf("unexpected result word %h", result_word));
                else
                begin
                    want = reduced_q.pop_front();
                    if (result_word !== want.word)
                        flag_mismatch($sformatf("result_word %0d: got %h, want %h",
                                                pos, result_word, want.word));
                    if (result_last !== want.word_last)
                        flag_mismatch($sformatf("result_last %0d: got %b, want %b",
                                                pos, result_last, want.word_last));
                end
                results_checked++;
            end
        end
    end

    initial
    begin
        dir_row_t    rows [2];
        int          r;
        int          k;
        int          p;
        int          n;
        int          nprod;
        int          pick;
        logic [63:0] w;

        rst_n         <= 1'b0;
        product_valid <= 1'b0;
        product_word  <= '0;
        cfg_write     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        gaps_on  = 1'b1;
        hold_req = 1'b0;
        mont_acc = '0;
        column   = 0;
        for (k = 0; k < CFG_COUNT; k++)
            modp1_words[k] = '0;

        // registers at reset are zero, so the result is just the high half
        rows[0] = '{load_ones: 1'b0, low_fill: '0, high_fill: ALL_ONES,
                    typed: 1'b1, typed_word: ALL_ONES};
        rows[1] = '{load_ones: 1'b1, low_fill: ALL_ONES, high_fill: ALL_ONES,
                    typed: 1'b0, typed_word: '0};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < 2; r++)
        begin
            if (rows[r].load_ones)
            begin
                settle();
                program_modulus(FILL_ONES);
            end
            for (k = 0; k < PRODUCT_WORDS; k++)
                send_word((k < FIELD_WORDS) ? rows[r].low_fill : rows[r].high_fill,
                          rows[r].typed, rows[r].typed_word);
        end

        for (p = 0; words_in < WORD_TARGET; p++)
        begin
            settle();
            program_modulus((p == 0) ? FILL_ZERO : (p == 1) ? FILL_ONES : FILL_RANDOM);
            gaps_on = (p != 3);
            // phase 2 backs the block up behind a long receiver hold
            if (p == 2)
                hold_req = 1'b1;
            nprod = (p == 2) ? 4 : (p == 3) ? 3 : $urandom_range(1, 3);
            for (n = 0; n < nprod; n++)
            begin
                for (k = 0; k < PRODUCT_WORDS; k++)
                begin
                    pick = $urandom_range(0, 9);
                    w = (pick == 0) ? '0 : (pick == 1) ? ALL_ONES : {$urandom, $urandom};
                    send_word(w, 1'b0, '0);
                end
            end
        end
        gaps_on = 1'b1;

        settle();
        $display("reduced %0d products (%0d words in) under %0d register settings",
                 products_done, words_in, settings_used);
        $display("checked %0d result words, %0d mismatches", results_checked, error_count);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
